FILE: src/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// shared types and constants of the round-robin task scheduler
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int TaskSlotsDefault = 8;

  // operation codes of a request word
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_DELAY = 3'd1,
    OP_PICK  = 3'd2,
    OP_ADD   = 3'd3,
    OP_SAVE  = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] delay_ticks;
    logic [31:0] stack_pointer;
  } req_word_t;

  typedef struct packed {
    logic [2:0]  running_slot;
    logic [31:0] running_stack_pointer;
    logic [7:0]  ready_mask;
    logic        accepted;
  } rsp_word_t;

endpackage

FILE: src/rrts_req_if.sv
// ----------------------------------------------------------------------------
// rrts_req_if
// request channel: one scheduler operation per word
// ----------------------------------------------------------------------------
interface rrts_req_if;
  logic                valid;
  logic                ready;
  rrts_pkg::req_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/rrts_rsp_if.sv
// ----------------------------------------------------------------------------
// rrts_rsp_if
// response channel: one scheduler status word per request
// ----------------------------------------------------------------------------
interface rrts_rsp_if;
  logic                valid;
  logic                ready;
  rrts_pkg::rsp_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/round_robin_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_top
// sequence: add, delay, save and unknown ops pass through a stack read state to
// the staging state; tick reads one wake tick per slot from slot 1 up, each
// compared while the next is read, then a final compare; pick tests one slot per cycle
// flow: one word in flight, the next is taken the cycle after the response
// is staged; staging waits while the response output is stalled
// async reset clears tick count, table flags and fill count; running slot 1
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_top #(
  parameter int TASK_SLOTS = rrts_pkg::TaskSlotsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  rrts_req_if.sink       req_i,
  rrts_rsp_if.source     rsp_o
);
  import rrts_pkg::*;

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
  localparam int EXT_W  = (TASK_SLOTS > 8) ? TASK_SLOTS : 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_TICK_END,
    ST_PICK,
    ST_STK_RD,
    ST_DONE
  } state_e;

  // control state
  state_e                  state_q;
  logic [31:0]             tick_q;
  logic [SLOT_W-1:0]       running_q;
  logic [CNT_W-1:0]        tasks_q;
  logic [TASK_SLOTS-1:0]   blocked_q;
  logic [TASK_SLOTS-1:0]   valid_q;
  logic                    acc_q;

  // walk over the slot table, shared by tick and pick
  logic [SLOT_W-1:0]       walk_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [SLOT_W-1:0]       cmp_idx_q;
  logic                    cmp_vld_q;

  // staged response word
  logic                    out_valid_q;
  rsp_word_t               out_q;

  // wake tick and stack pointer tables, one write and one read port each
  logic [31:0]             wake_mem [TASK_SLOTS];
  logic [31:0]             stk_mem  [TASK_SLOTS];
  logic [31:0]             wake_rd_q;
  logic [31:0]             stk_rd_q;

  logic                    wake_we;
  logic [SLOT_W-1:0]       wake_waddr;
  logic [31:0]             wake_wdata;
  logic                    stk_we;
  logic [SLOT_W-1:0]       stk_waddr;
  logic [31:0]             stk_wdata;

  logic                    req_fire;
  logic                    out_free;
  logic                    table_full;
  logic [SLOT_W-1:0]       add_slot;
  logic [SLOT_W-1:0]       next_slot;
  logic                    walk_hit;
  logic                    wake_match;
  logic [TASK_SLOTS-1:0]   ready_vec;
  logic [EXT_W-1:0]        ready_ext;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  assign table_full  = (tasks_q >= CNT_W'(TASK_SLOTS));
  assign add_slot    = tasks_q[SLOT_W-1:0];

  // slot after the running one, cyclic
  assign next_slot   = (running_q == SLOT_W'(TASK_SLOTS - 1)) ? '0
                                                              : running_q + SLOT_W'(1);

  // pick: idle slot 0 is never chosen by the walk
  assign walk_hit    = (walk_q != '0) && valid_q[walk_q] && !blocked_q[walk_q];

  // tick: compare the wake tick read last cycle with the new count
  assign wake_match  = cmp_vld_q && blocked_q[cmp_idx_q] && (wake_rd_q == tick_q);

  assign ready_vec   = valid_q & ~blocked_q;
  assign ready_ext   = EXT_W'(ready_vec);

  // table writes happen only in the accept cycle
  always_comb begin
    wake_we    = 1'b0;
    wake_waddr = running_q;
    wake_wdata = tick_q + req_i.data.delay_ticks;
    stk_we     = 1'b0;
    stk_waddr  = running_q;
    stk_wdata  = req_i.data.stack_pointer;
    if (req_fire) begin
      case (req_i.data.op)
        OP_DELAY: begin
          wake_we = (running_q != '0);
        end
        OP_ADD: begin
          wake_we    = !table_full;
          wake_waddr = add_slot;
          wake_wdata = '0;
          stk_we     = !table_full;
          stk_waddr  = add_slot;
        end
        OP_SAVE: begin
          stk_we = 1'b1;
        end
        default: begin
          wake_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wake_we) begin
      wake_mem[wake_waddr] <= wake_wdata;
    end
    wake_rd_q <= wake_mem[walk_q];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[running_q];
  end

  // sequencer: holds control state and the staged response
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      running_q   <= SLOT_W'(1);
      tasks_q     <= '0;
      blocked_q   <= '0;
      valid_q     <= '0;
      acc_q       <= 1'b0;
      walk_q      <= '0;
      cnt_q       <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // a staged word leaves; ST_DONE restages on its own
      if (out_valid_q && rsp_o.ready && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          cmp_vld_q <= 1'b0;
          if (req_fire) begin
            case (req_i.data.op)
              OP_TICK: begin
                acc_q   <= 1'b1;
                tick_q  <= tick_q + 32'd1;
                walk_q  <= SLOT_W'(1);
                state_q <= ST_TICK;
              end
              OP_DELAY: begin
                // delay from idle is refused
                acc_q   <= (running_q != '0);
                state_q <= ST_STK_RD;
                if (running_q != '0) begin
                  blocked_q[running_q] <= 1'b1;
                end
              end
              OP_PICK: begin
                acc_q   <= 1'b1;
                walk_q  <= next_slot;
                cnt_q   <= CNT_W'(1);
                state_q <= ST_PICK;
              end
              OP_ADD: begin
                acc_q   <= !table_full;
                state_q <= ST_STK_RD;
                if (!table_full) begin
                  valid_q[add_slot]   <= 1'b1;
                  blocked_q[add_slot] <= 1'b0;
                  tasks_q             <= tasks_q + CNT_W'(1);
                end
              end
              OP_SAVE: begin
                acc_q   <= 1'b1;
                state_q <= ST_STK_RD;
              end
              default: begin
                acc_q   <= 1'b0;
                state_q <= ST_STK_RD;
              end
            endcase
          end
        end

        // issue one wake tick read per cycle, compare the previous one
        ST_TICK: begin
          if (wake_match) begin
            blocked_q[cmp_idx_q] <= 1'b0;
          end
          cmp_idx_q <= walk_q;
          cmp_vld_q <= 1'b1;
          if (walk_q == SLOT_W'(TASK_SLOTS - 1)) begin
            state_q <= ST_TICK_END;
          end else begin
            walk_q <= walk_q + SLOT_W'(1);
          end
        end

        ST_TICK_END: begin
          if (wake_match) begin
            blocked_q[cmp_idx_q] <= 1'b0;
          end
          cmp_vld_q <= 1'b0;
          state_q   <= ST_STK_RD;
        end

        // test one slot per cycle, the running slot itself last
        ST_PICK: begin
          if (walk_hit) begin
            running_q <= walk_q;
            state_q   <= ST_STK_RD;
          end else if (cnt_q == CNT_W'(TASK_SLOTS)) begin
            running_q <= '0;
            state_q   <= ST_STK_RD;
          end else begin
            walk_q <= (walk_q == SLOT_W'(TASK_SLOTS - 1)) ? '0 : walk_q + SLOT_W'(1);
            cnt_q  <= cnt_q + CNT_W'(1);
          end
        end

        // stack table read of the running slot lands in stk_rd_q
        ST_STK_RD: begin
          state_q <= ST_DONE;
        end

        ST_DONE: begin
          if (out_free) begin
            out_valid_q                 <= 1'b1;
            out_q.running_slot          <= 3'(running_q);
            out_q.running_stack_pointer <= stk_rd_q;
            out_q.ready_mask            <= ready_ext[7:0];
            out_q.accepted              <= acc_q;
            state_q                     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
